### hw/rtl/mss_pkg.sv
// ----------------------------------------------------------------------------
// mss_pkg
// Shared types and constants for the maximum segment sum tree.
// ----------------------------------------------------------------------------
package mss_pkg;

   // Width of the reported segment sum
   localparam int unsigned SUM_BITS = 41;

   // Sequencer states
   typedef enum logic [1:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_CLIMB
   } state_type;

endpackage

### hw/rtl/mss_merge.sv
// ----------------------------------------------------------------------------
// mss_merge
// Combine two child nodes into their parent: total, best prefix, best suffix
// and best segment, with the empty segment counting as zero.
// ----------------------------------------------------------------------------
module mss_merge import mss_pkg::*; #(
   parameter int unsigned NODE_BITS = 42
) (
   input  logic [4*NODE_BITS-1:0] left_node,
   input  logic [4*NODE_BITS-1:0] right_node,
   output logic [4*NODE_BITS-1:0] parent_node
);

   logic signed [NODE_BITS-1:0] l_tot, l_pre, l_suf, l_seg;
   logic signed [NODE_BITS-1:0] r_tot, r_pre, r_suf, r_seg;
   logic signed [NODE_BITS-1:0] p_tot, p_pre, p_suf, p_seg;
   logic signed [NODE_BITS-1:0] pre_span, suf_span, mid_span, child_seg;

   // Unpack {total, prefix, suffix, segment}
   assign {l_tot, l_pre, l_suf, l_seg} = left_node;
   assign {r_tot, r_pre, r_suf, r_seg} = right_node;

   // Candidate sums that span the split point
   assign pre_span = l_tot + r_pre;
   assign suf_span = r_tot + l_suf;
   assign mid_span = l_suf + r_pre;

   // Pick the best of each
   assign p_tot     = l_tot + r_tot;
   assign p_pre     = (pre_span > l_pre) ? pre_span : l_pre;
   assign p_suf     = (suf_span > r_suf) ? suf_span : r_suf;
   assign child_seg = (r_seg > l_seg) ? r_seg : l_seg;
   assign p_seg     = (mid_span > child_seg) ? mid_span : child_seg;

   assign parent_node = {p_tot, p_pre, p_suf, p_seg};

endmodule

### hw/rtl/max_subarray_sum_segment_tree.sv
// ----------------------------------------------------------------------------
// max_subarray_sum_segment_tree
// Point-update segment tree reporting the largest contiguous segment sum.
// ----------------------------------------------------------------------------
// Usage:
//   Raise start with req_index and req_value while busy is low; that beat
//   overwrites one element. Exactly one result beat follows: rsp_valid is
//   high for one cycle with rsp_max_segment_sum, the best segment sum of the
//   whole array (empty segment counts as zero).
//   An in-range write stores the leaf, then climbs one tree level per cycle,
//   reading the sibling from the node memory while the previous level is
//   merged and written back. The result appears once the climb has written
//   the root, and busy drops in the same cycle, so a new write is taken
//   only once the previous one has been reported.
//   An index at or beyond LEAVES writes nothing; its result (the current sum)
//   follows in the cycle after the start beat and busy stays low.
//   After reset the node memory is cleared one entry a cycle, all
//   2*2^LEVELS entries (2048 at 1024 leaves); busy stays high until done.
//   The receiver cannot stall; each result is shown for a single cycle.
// ----------------------------------------------------------------------------
module max_subarray_sum_segment_tree import mss_pkg::*; #(
   parameter int unsigned LEAVES     = 1024,
   parameter int unsigned VALUE_BITS = 32
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  logic [$clog2(LEAVES)-1:0]     req_index,
   input  logic [VALUE_BITS-1:0]         req_value,
   output logic                          rsp_valid,
   output logic [SUM_BITS-1:0]           rsp_max_segment_sum
);

   localparam int unsigned LEVELS    = $clog2(LEAVES);
   localparam int unsigned ADDR_BITS = LEVELS + 1;
   localparam int unsigned DEPTH     = 2 ** ADDR_BITS;
   localparam int unsigned NODE_BITS = VALUE_BITS + LEVELS;
   localparam int unsigned WORD_BITS = 4 * NODE_BITS;
   localparam int unsigned EXT_BITS  = (NODE_BITS > SUM_BITS) ? NODE_BITS : SUM_BITS;
   localparam logic [ADDR_BITS-1:0] ROOT_ADDR = ADDR_BITS'(1);
   localparam logic [ADDR_BITS-1:0] LAST_ADDR = ADDR_BITS'(DEPTH - 1);

   state_type state_ff, state_in;

   logic [ADDR_BITS-1:0] node_ff, node_in;
   logic [WORD_BITS-1:0] cur_ff, cur_in;
   logic [ADDR_BITS-1:0] clr_ff, clr_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [SUM_BITS-1:0]  rsp_sum_ff, rsp_sum_in;

   logic [WORD_BITS-1:0] node_mem [0:DEPTH-1];
   logic                 wr_en;
   logic [ADDR_BITS-1:0] wr_addr, rd_addr;
   logic [WORD_BITS-1:0] wr_data, rd_data_ff;

   logic                        accept, in_range;
   logic [ADDR_BITS-1:0]        leaf_addr, parent_addr;
   logic signed [NODE_BITS-1:0] leaf_val, leaf_pos;
   logic [WORD_BITS-1:0]        leaf_word, left_word, right_word, parent_word;
   logic [EXT_BITS-1:0]         seg_ext;

   // Input decode
   assign accept      = start && (state_ff == ST_IDLE);
   assign in_range    = ({1'b0, req_index} < ADDR_BITS'(LEAVES));
   assign leaf_addr   = {1'b1, req_index};
   assign parent_addr = node_ff >> 1;

   // Build the leaf word from the sign-extended value
   assign leaf_val  = {{LEVELS{req_value[VALUE_BITS-1]}}, req_value};
   assign leaf_pos  = leaf_val[NODE_BITS-1] ? '0 : leaf_val;
   assign leaf_word = {leaf_val, leaf_pos, leaf_pos, leaf_pos};

   // Order children by the side the climbing node sits on
   assign left_word  = node_ff[0] ? rd_data_ff : cur_ff;
   assign right_word = node_ff[0] ? cur_ff : rd_data_ff;

   mss_merge #(
      .NODE_BITS (NODE_BITS)
   ) u_merge (
      .left_node   (left_word),
      .right_node  (right_word),
      .parent_node (parent_word)
   );

   // Best segment is never negative: zero-extend, then trim to the port
   assign seg_ext = EXT_BITS'(parent_word[NODE_BITS-1:0]);

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_CLEAR: begin
            if (clr_ff == LAST_ADDR) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (accept && in_range) begin
               state_in = ST_CLIMB;
            end
         end
         ST_CLIMB: begin
            if (parent_addr == ROOT_ADDR) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_CLEAR;
         end
      endcase
   end

   // Memory control and datapath
   always_comb begin
      wr_en        = 1'b0;
      wr_addr      = clr_ff;
      wr_data      = '0;
      rd_addr      = node_ff;
      node_in      = node_ff;
      cur_in       = cur_ff;
      clr_in       = clr_ff;
      rsp_valid_in = 1'b0;
      rsp_sum_in   = rsp_sum_ff;
      case (state_ff)
         ST_CLEAR: begin
            // Zero one entry per cycle
            wr_en  = 1'b1;
            clr_in = clr_ff + ADDR_BITS'(1);
         end
         ST_IDLE: begin
            if (accept) begin
               if (in_range) begin
                  // Store the leaf and fetch its sibling
                  wr_en   = 1'b1;
                  wr_addr = leaf_addr;
                  wr_data = leaf_word;
                  rd_addr = leaf_addr ^ ADDR_BITS'(1);
                  node_in = leaf_addr;
                  cur_in  = leaf_word;
               end else begin
                  // Ignore the write, report the current sum
                  rsp_valid_in = 1'b1;
               end
            end
         end
         ST_CLIMB: begin
            // Write the parent and fetch the next sibling
            wr_en   = 1'b1;
            wr_addr = parent_addr;
            wr_data = parent_word;
            rd_addr = parent_addr ^ ADDR_BITS'(1);
            node_in = parent_addr;
            cur_in  = parent_word;
            if (parent_addr == ROOT_ADDR) begin
               rsp_valid_in = 1'b1;
               rsp_sum_in   = seg_ext[SUM_BITS-1:0];
            end
         end
         default: begin
            wr_en = 1'b0;
         end
      endcase
   end

   // Node memory: one write and one registered read per cycle
   always_ff @(posedge clock) begin
      if (wr_en) begin
         node_mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      rd_data_ff <= node_mem[rd_addr];
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         rsp_sum_ff   <= '0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         rsp_valid_ff <= rsp_valid_in;
         rsp_sum_ff   <= rsp_sum_in;
      end
   end

   // Climb payload
   always_ff @(posedge clock) begin
      node_ff <= node_in;
      cur_ff  <= cur_in;
   end

   assign busy                = (state_ff != ST_IDLE);
   assign rsp_valid           = rsp_valid_ff;
   assign rsp_max_segment_sum = rsp_sum_ff;

endmodule

### dv/max_subarray_sum_segment_tree_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// max_subarray_sum_segment_tree_tb
// Drives point writes into the segment tree and checks every reported sum.
// A class keeps its own copy of the tree, recomputes the path to the root on
// each accepted write and queues the expected best segment sum; each result
// beat is compared against the oldest queued sum. Directed extremes come
// first, then three random phases with different sender gap rates.
// ----------------------------------------------------------------------------
module max_subarray_sum_segment_tree_tb import mss_pkg::*; ();

   localparam int unsigned LEAVES      = 1024;
   localparam int unsigned VALUE_BITS  = 32;
   localparam int unsigned INDEX_BITS  = $clog2(LEAVES);
   localparam int unsigned LATENCY     = INDEX_BITS + 1;
   localparam int unsigned STALL_LIMIT = 8000;
   localparam int unsigned PHASE_ITEMS = 135;

   typedef logic [INDEX_BITS-1:0] index_type;
   typedef logic [VALUE_BITS-1:0] value_type;
   typedef logic [SUM_BITS-1:0]   sum_type;

   // Shadow tree and queue of sums still owed by the block
   class segment_sum_tracker_type;
      longint  seg_total[2*LEAVES];
      longint  seg_prefix[2*LEAVES];
      longint  seg_suffix[2*LEAVES];
      longint  seg_best[2*LEAVES];
      sum_type expected_sums[$];
      int      mismatches;

      function new();
         mismatches = 0;
         for (int k = 0; k < 2*LEAVES; k++) begin
            seg_total[k]  = 0;
            seg_prefix[k] = 0;
            seg_suffix[k] = 0;
            seg_best[k]   = 0;
         end
      endfunction

      function automatic longint max_of(longint a, longint b);
         return (a > b) ? a : b;
      endfunction

      // Store the leaf, merge every ancestor up to the root
      function void note_write(index_type idx, value_type val);
         int unsigned k;
         int unsigned lc;
         longint      leaf;
         leaf = longint'($signed(val));
         k = LEAVES + idx;
         seg_total[k]  = leaf;
         seg_prefix[k] = max_of(0, leaf);
         seg_suffix[k] = seg_prefix[k];
         seg_best[k]   = seg_prefix[k];
         k = k >> 1;
         while (k >= 1) begin
            lc = 2 * k;
            seg_total[k]  = seg_total[lc] + seg_total[lc+1];
            seg_prefix[k] = max_of(seg_prefix[lc], seg_total[lc] + seg_prefix[lc+1]);
            seg_suffix[k] = max_of(seg_suffix[lc+1], seg_total[lc+1] + seg_suffix[lc]);
            seg_best[k]   = max_of(max_of(seg_best[lc], seg_best[lc+1]),
                                   seg_suffix[lc] + seg_prefix[lc+1]);
            k = k >> 1;
         end
         expected_sums.insert(expected_sums.size(), sum_type'(seg_best[1]));
      endfunction

      task report(string msg);
         $display("MISMATCH @%0t: %s", $realtime, msg);
         mismatches++;
      endtask

      // Compare one result beat with the oldest owed sum
      task check_sum(sum_type got);
         sum_type want;
         if (expected_sums.size() == 0) begin
            report($sformatf("unexpected result beat, sum %0d", got));
         end else begin
            want = expected_sums.pop_front();
            if (got !== want)
               report($sformatf("max_segment_sum got %0d want %0d", got, want));
         end
      endtask

      function int pending();
         return expected_sums.size();
      endfunction
   endclass

   logic      clock;
   logic      reset     = 1'b1;
   logic      start     = 1'b0;
   index_type req_index = '0;
   value_type req_value = '0;
   logic      busy;
   logic      rsp_valid;
   sum_type   rsp_max_segment_sum;

   segment_sum_tracker_type tracker = new();
   int unsigned             quiet_cycles = 0;
   int unsigned             gap_pct = 0;
   int unsigned             cursor = 0;

   max_subarray_sum_segment_tree #(
      .LEAVES     (LEAVES),
      .VALUE_BITS (VALUE_BITS)
   ) i_dut (
      .clock               (clock),
      .reset               (reset),
      .start               (start),
      .busy                (busy),
      .req_index           (req_index),
      .req_value           (req_value),
      .rsp_valid           (rsp_valid),
      .rsp_max_segment_sum (rsp_max_segment_sum)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // Check result beats first, then note a write accepted at the same edge
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid)
            tracker.check_sum(rsp_max_segment_sum);
         if (start && !busy)
            tracker.note_write(req_index, req_value);
      end
   end

   // Watchdog: end the run when nothing moves for too long
   always @(posedge clock) begin
      if (reset || rsp_valid || (start && !busy)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
         $display("max_subarray_sum_segment_tree_tb NOT OK");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // Hold one write on the request ports until a start beat is taken
   task automatic send_write(index_type idx, value_type val);
      start     <= 1'b1;
      req_index <= idx;
      req_value <= val;
      do @(posedge clock); while (busy);
      @(negedge clock);
   endtask

   // Drop start for a random number of cycles, junk on the data ports
   task automatic sender_gap();
      while ($urandom_range(99) < gap_pct) begin
         start     <= 1'b0;
         req_index <= index_type'($urandom);
         req_value <= value_type'($urandom);
         @(negedge clock);
      end
   endtask

   task automatic drain_results();
      start <= 1'b0;
      while (tracker.pending() != 0)
         @(negedge clock);
   endtask

   function automatic value_type pick_value();
      case ($urandom_range(9))
         0:       return value_type'(32'h7FFF_FFFF);
         1:       return value_type'(32'h8000_0000);
         2:       return '1;
         3:       return '0;
         4, 5:    return value_type'($urandom_range(2000)) - value_type'(1000);
         6, 7:    return value_type'($urandom) >> 1;
         default: return value_type'($urandom);
      endcase
   endfunction

   // Mostly writes clustered around a moving cursor, so segments build up
   function automatic index_type pick_index();
      case ($urandom_range(9))
         0, 1, 2: return index_type'($urandom);
         3, 4:    return index_type'(cursor++);
         default: return index_type'(cursor + $urandom_range(15));
      endcase
   endfunction

   initial begin
      index_type dir_index[20];
      value_type dir_value[20];
      dir_index = '{10'd0,    10'd1023, 10'd512,  10'd511,  10'd1,
                    10'd0,    10'd1023, 10'd512,  10'd0,    10'd341,
                    10'd682,  10'd1022, 10'd1023, 10'd2,    10'd3,
                    10'd4,    10'd511,  10'd1,    10'd0,    10'd682};
      dir_value = '{32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF,
                    32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0000, 32'h0000_0001,
                    32'hFFFF_FFFF, 32'h5555_5555, 32'hAAAA_AAAA, 32'h8000_0000,
                    32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                    32'h0000_0000, 32'hFFFF_FFFE, 32'h0000_0000, 32'h0000_0000};

      // Hold reset, then release it on a falling edge
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed extremes, back to back
      gap_pct = 0;
      foreach (dir_index[i])
         send_write(dir_index[i], dir_value[i]);
      drain_results();

      // Random phases: light gaps, heavy gaps, none; drain fully in between
      for (int phase = 0; phase < 3; phase++) begin
         gap_pct = (phase == 0) ? 20 : (phase == 1) ? 70 : 0;
         cursor  = $urandom_range(LEAVES - 1);
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            sender_gap();
            send_write(pick_index(), pick_value());
         end
         drain_results();
      end

      // Let any stray beat show up before the verdict
      repeat (2 * LATENCY) @(posedge clock);
      while (tracker.pending() != 0)
         tracker.report($sformatf("sum %0d never reported",
                                  tracker.expected_sums.pop_front()));
      if (tracker.mismatches == 0)
         $display("max_subarray_sum_segment_tree_tb OK");
      else
         $display("max_subarray_sum_segment_tree_tb NOT OK");
      $finish;
   end

endmodule

### sim.f
hw/rtl/mss_pkg.sv
hw/rtl/mss_merge.sv
hw/rtl/max_subarray_sum_segment_tree.sv
dv/max_subarray_sum_segment_tree_tb.sv
